### src/tnm_pkg.sv
// Shared types and constants for the torus neighborhood trait mean unit.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package tnm_pkg;

  localparam int DIM_W      = 7;
  localparam int ROW_W      = 6;
  localparam int TRAIT_IN_W = 17;
  localparam int MEAN_W     = 17;
  localparam int COUNT_W    = 5;

  localparam logic [DIM_W-1:0] MIN_DIM = 7'd5;

  localparam logic       REQ_WRITE = 1'b0;
  localparam logic       REQ_QUERY = 1'b1;

  localparam logic       CFG_GRID_ROWS = 1'b0;
  localparam logic       CFG_GRID_COLS = 1'b1;

  localparam logic [1:0] CELL_STATE_A = 2'd1;
  localparam logic [1:0] CELL_STATE_B = 2'd2;

  localparam logic [2:0] WIN_MID  = 3'd2;
  localparam logic [2:0] WIN_LAST = 3'd4;
  localparam logic [1:0] RED_LAST = 2'd3;

  localparam logic [COUNT_W-1:0] MAX_ALIVE = 5'd24;

  typedef struct packed {
    logic                  req_type;
    logic [ROW_W-1:0]      cell_row;
    logic [ROW_W-1:0]      cell_col;
    logic [1:0]            cell_state;
    logic [TRAIT_IN_W-1:0] trait_a;
    logic [TRAIT_IN_W-1:0] trait_b;
  } tnm_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_trait;
    logic [COUNT_W-1:0] alive_count;
  } tnm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WINIT,
    ST_WALK,
    ST_DRAIN,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } tnm_state_e;

  typedef struct packed {
    logic       cell_wr;
    logic       capture;
    logic       red_step;
    logic [1:0] red_shift;
    logic       win_init;
    logic       win_rd;
    logic       win_col_wrap;
    logic       win_center;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } tnm_cmd_t;

  typedef struct packed {
    logic alive_zero;
  } tnm_stat_t;

endpackage

`default_nettype wire

### src/tnm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module tnm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/tnm_ctrl.sv
// Controller state machine for the torus neighborhood trait mean unit.
// Depends on tnm_pkg; drives the datapath through tnm_cmd_t.
`default_nettype none

module tnm_ctrl #(
  parameter int TRAIT_FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_req_type_i,
  output      logic               in_stall_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  input  wire tnm_pkg::tnm_stat_t stat_i,
  output      tnm_pkg::tnm_cmd_t  cmd_o
);

  localparam int SW  = TRAIT_FRAC_BITS + 1 + tnm_pkg::COUNT_W;
  localparam int DCW = $clog2(SW);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(SW - 1);

  tnm_pkg::tnm_state_e state_q, state_d;
  logic [1:0]          red_cnt_q, red_cnt_d;
  logic [2:0]          dr_q, dr_d;
  logic [2:0]          dc_q, dc_d;
  logic [DCW-1:0]      div_cnt_q, div_cnt_d;
  logic                out_valid_q, out_valid_d;
  tnm_pkg::tnm_cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnm_pkg::ST_IDLE;
      red_cnt_q   <= '0;
      dr_q        <= '0;
      dc_q        <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      red_cnt_q   <= red_cnt_d;
      dr_q        <= dr_d;
      dc_q        <= dc_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    red_cnt_d = red_cnt_q;
    dr_d      = dr_q;
    dc_d      = dc_q;
    div_cnt_d = div_cnt_q;
    cmd       = '0;
    case (state_q)
      tnm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_type_i == tnm_pkg::REQ_QUERY) begin
            cmd.capture = 1'b1;
            red_cnt_d   = '0;
            state_d     = tnm_pkg::ST_REDUCE;
          end else begin
            cmd.cell_wr = 1'b1;
          end
        end
      end
      tnm_pkg::ST_REDUCE: begin
        cmd.red_step  = 1'b1;
        cmd.red_shift = ~red_cnt_q;
        red_cnt_d     = red_cnt_q + 2'd1;
        if (red_cnt_q == tnm_pkg::RED_LAST) begin
          state_d = tnm_pkg::ST_WINIT;
        end
      end
      tnm_pkg::ST_WINIT: begin
        cmd.win_init = 1'b1;
        dr_d         = '0;
        dc_d         = '0;
        state_d      = tnm_pkg::ST_WALK;
      end
      tnm_pkg::ST_WALK: begin
        cmd.win_rd       = 1'b1;
        cmd.win_col_wrap = (dc_q == tnm_pkg::WIN_LAST);
        cmd.win_center   = (dr_q == tnm_pkg::WIN_MID) && (dc_q == tnm_pkg::WIN_MID);
        if (dc_q == tnm_pkg::WIN_LAST) begin
          dc_d = '0;
          dr_d = dr_q + 3'd1;
          if (dr_q == tnm_pkg::WIN_LAST) begin
            state_d = tnm_pkg::ST_DRAIN;
          end
        end else begin
          dc_d = dc_q + 3'd1;
        end
      end
      tnm_pkg::ST_DRAIN: begin
        state_d = tnm_pkg::ST_PREP;
      end
      tnm_pkg::ST_PREP: begin
        if (stat_i.alive_zero) begin
          state_d = tnm_pkg::ST_DONE;
        end else begin
          cmd.div_init = 1'b1;
          div_cnt_d    = '0;
          state_d      = tnm_pkg::ST_DIVIDE;
        end
      end
      tnm_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        div_cnt_d    = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          state_d = tnm_pkg::ST_DONE;
        end
      end
      tnm_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = tnm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tnm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd.out_load | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != tnm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

### src/tnm_dpath.sv
// Datapath for the torus neighborhood trait mean unit: grid size registers,
// cell memory, window walk, accumulation and a restoring divider.
// Depends on tnm_pkg and tnm_ram.
`default_nettype none

module tnm_dpath #(
  parameter int MAX_ROWS        = 64,
  parameter int MAX_COLS        = 64,
  parameter int TRAIT_FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tnm_pkg::tnm_in_t           in_data_i,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [tnm_pkg::DIM_W-1:0]  cfg_data_i,
  input  wire tnm_pkg::tnm_cmd_t          cmd_i,
  output      tnm_pkg::tnm_stat_t         stat_o,
  output      tnm_pkg::tnm_out_t          out_data_o
);

  localparam int DW    = tnm_pkg::DIM_W;
  localparam int CW    = tnm_pkg::COUNT_W;
  localparam int TW    = TRAIT_FRAC_BITS + 1;
  localparam int EW    = 2 + 2 * TW;
  localparam int SW    = TW + CW;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [DW-1:0] ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : DW'(MAX_ROWS);
  localparam logic [DW-1:0] COLS_CAP = (MAX_COLS > 127) ? 7'd127 : DW'(MAX_COLS);
  localparam logic [DW-1:0] ROWS_RST = (MAX_ROWS < 64) ? DW'(MAX_ROWS) : 7'd64;
  localparam logic [DW-1:0] COLS_RST = (MAX_COLS < 64) ? DW'(MAX_COLS) : 7'd64;

  logic [DW-1:0]   grid_rows_q, grid_cols_q;
  logic [DW-1:0]   rows_wr, cols_wr;
  logic [DW-1:0]   cr_q, cc_q;
  logic [DW+2:0]   rows_sh, cols_sh;
  logic [DW:0]     r_start, c_start;
  logic [DW-1:0]   r_q, c_q, c0_q;
  logic [DW-1:0]   r_inc, c_inc;
  logic            acc_pend_q;
  logic [SW-1:0]   sum_q;
  logic [CW-1:0]   cnt_q;
  logic [SW-1:0]   quo_q;
  logic [CW-1:0]   rem_q;
  logic [CW:0]     rem_sh;
  logic            wr_ok;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;
  logic [1:0]      rd_state;
  logic [TW-1:0]   rd_a, rd_b;
  tnm_pkg::tnm_out_t out_q;

  // Grid size registers, clamped to the supported range on write.
  always_comb begin
    if (cfg_data_i < tnm_pkg::MIN_DIM) begin
      rows_wr = tnm_pkg::MIN_DIM;
    end else if (cfg_data_i > ROWS_CAP) begin
      rows_wr = ROWS_CAP;
    end else begin
      rows_wr = cfg_data_i;
    end
    if (cfg_data_i < tnm_pkg::MIN_DIM) begin
      cols_wr = tnm_pkg::MIN_DIM;
    end else if (cfg_data_i > COLS_CAP) begin
      cols_wr = COLS_CAP;
    end else begin
      cols_wr = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= ROWS_RST;
      grid_cols_q <= COLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tnm_pkg::CFG_GRID_ROWS: grid_rows_q <= rows_wr;
        tnm_pkg::CFG_GRID_COLS: grid_cols_q <= cols_wr;
        default: ;
      endcase
    end
  end

  // Cell memory.
  assign wr_ok = cmd_i.cell_wr && (int'(in_data_i.cell_row) < MAX_ROWS) &&
                 (int'(in_data_i.cell_col) < MAX_COLS);
  assign waddr = AW'(int'(in_data_i.cell_row) * MAX_COLS + int'(in_data_i.cell_col));
  assign wdata = {in_data_i.cell_state, TW'(in_data_i.trait_a), TW'(in_data_i.trait_b)};
  assign raddr = AW'(int'(r_q) * MAX_COLS + int'(c_q));

  tnm_ram #(
    .WIDTH (EW),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_state = rdata[EW-1 -: 2];
  assign rd_a     = rdata[2*TW-1 -: TW];
  assign rd_b     = rdata[TW-1:0];

  // Center reduction modulo the grid size, one shifted subtract per step.
  assign rows_sh = {3'b000, grid_rows_q} << cmd_i.red_shift;
  assign cols_sh = {3'b000, grid_cols_q} << cmd_i.red_shift;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cr_q <= DW'(in_data_i.cell_row);
      cc_q <= DW'(in_data_i.cell_col);
    end else if (cmd_i.red_step) begin
      if ({3'b000, cr_q} >= rows_sh) begin
        cr_q <= DW'({3'b000, cr_q} - rows_sh);
      end
      if ({3'b000, cc_q} >= cols_sh) begin
        cc_q <= DW'({3'b000, cc_q} - cols_sh);
      end
    end
  end

  // Window walk pointers with wrap-around.
  always_comb begin
    r_start = {1'b0, cr_q} + {1'b0, grid_rows_q} - (DW+1)'(2);
    if (r_start >= {1'b0, grid_rows_q}) begin
      r_start = r_start - {1'b0, grid_rows_q};
    end
    c_start = {1'b0, cc_q} + {1'b0, grid_cols_q} - (DW+1)'(2);
    if (c_start >= {1'b0, grid_cols_q}) begin
      c_start = c_start - {1'b0, grid_cols_q};
    end
    r_inc = (r_q == grid_rows_q - 1'b1) ? '0 : r_q + 1'b1;
    c_inc = (c_q == grid_cols_q - 1'b1) ? '0 : c_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      r_q  <= DW'(r_start);
      c_q  <= DW'(c_start);
      c0_q <= DW'(c_start);
    end else if (cmd_i.win_rd) begin
      if (cmd_i.win_col_wrap) begin
        c_q <= c0_q;
        r_q <= r_inc;
      end else begin
        c_q <= c_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_pend_q <= 1'b0;
    end else begin
      acc_pend_q <= cmd_i.win_rd && !cmd_i.win_center;
    end
  end

  // Accumulation of alive neighbors.
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (acc_pend_q) begin
      if (rd_state == tnm_pkg::CELL_STATE_A) begin
        sum_q <= sum_q + SW'(rd_a);
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_state == tnm_pkg::CELL_STATE_B) begin
        sum_q <= sum_q + SW'(rd_b);
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[SW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, cnt_q}) begin
        rem_q <= CW'(rem_sh - {1'b0, cnt_q});
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= CW'(rem_sh);
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.mean_trait  <= (cnt_q == '0) ? '0 : tnm_pkg::MEAN_W'(quo_q);
      out_q.alive_count <= cnt_q;
    end
  end

  assign stat_o.alive_zero = (cnt_q == '0);
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

### src/torus_neighborhood_trait_mean_unit.sv
// Top level of the torus neighborhood trait mean unit.
// Depends on tnm_pkg, tnm_ctrl, tnm_dpath and tnm_ram.
//
// The unit holds a toroidal grid of cells in a single-port-read memory. A write
// transaction stores one cell and leaves the unit idle for the next transaction.
// A query transaction first reduces the center modulo the grid size with shifted
// subtracts, then sets up the window, reads the 5x5 window through the one memory
// read port, drains the read pipeline, and, unless no neighbor is alive, runs a
// restoring divider for the mean before the result enters the output register.
// One query is in work at a time, and the input is taken again as soon as the
// result is in the output register.
`default_nettype none

module torus_neighborhood_trait_mean_unit #(
  parameter int MAX_ROWS        = 64,
  parameter int MAX_COLS        = 64,
  parameter int TRAIT_FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire tnm_pkg::tnm_in_t          in_data_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      tnm_pkg::tnm_out_t         out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [tnm_pkg::DIM_W-1:0] cfg_data_i
);

  tnm_pkg::tnm_cmd_t  cmd;
  tnm_pkg::tnm_stat_t stat;

  tnm_ctrl #(
    .TRAIT_FRAC_BITS (TRAIT_FRAC_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  tnm_dpath #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_COLS        (MAX_COLS),
    .TRAIT_FRAC_BITS (TRAIT_FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("Result loaded over a transaction still waiting at the output.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.alive_count <= tnm_pkg::MAX_ALIVE))
    else $error("Alive count exceeds the window size.");

  a_zero_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.alive_count == '0)) |-> (out_data_o.mean_trait == '0))
    else $error("Nonzero mean with no alive neighbor.");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.win_rd |-> in_stall_o)
    else $error("Input open while the window is being read.");

endmodule

`default_nettype wire

### tb/tb_torus_neighborhood_trait_mean_unit.sv
// Self-checking testbench for torus_neighborhood_trait_mean_unit.
// Depends on tnm_pkg and the unit; a directed table and random sequences are checked
// against a cell-grid predictor or table results, under random input gaps and output stalls.
`timescale 1ns / 1ps

module tb_torus_neighborhood_trait_mean_unit;

  localparam int GRID_STRIDE  = 64;
  localparam int GRID_CELLS   = 4096;
  localparam int ITEMS        = 760;
  localparam int QUIET_ITEMS  = 120;
  localparam int PHASE_ITEMS  = 120;
  localparam int QUERY_CYCLES = 64;

  localparam int DIM_BITS   = tnm_pkg::DIM_W;
  localparam int ROW_BITS   = tnm_pkg::ROW_W;
  localparam int TRAIT_BITS = tnm_pkg::TRAIT_IN_W;
  localparam int MEAN_BITS  = tnm_pkg::MEAN_W;
  localparam int COUNT_BITS = tnm_pkg::COUNT_W;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_A     = tnm_pkg::CELL_STATE_A;
  localparam logic [1:0] CELL_B     = tnm_pkg::CELL_STATE_B;
  localparam logic [1:0] CELL_OTHER = 2'd3;
  localparam logic       CFG_ROWS   = tnm_pkg::CFG_GRID_ROWS;
  localparam logic       CFG_COLS   = tnm_pkg::CFG_GRID_COLS;

  typedef enum logic [1:0] {
    OP_FILL,
    OP_WRITE,
    OP_QUERY,
    OP_CFG
  } plan_op_e;

  typedef struct packed {
    plan_op_e              op;
    logic                  cfg_idx;
    logic [DIM_BITS-1:0]   cfg_val;
    logic [ROW_BITS-1:0]   row;
    logic [ROW_BITS-1:0]   col;
    logic [1:0]            st;
    logic [TRAIT_BITS-1:0] a;
    logic [TRAIT_BITS-1:0] b;
    logic                  typed;
    logic [MEAN_BITS-1:0]  mean;
    logic [COUNT_BITS-1:0] count;
  } plan_step_t;

  localparam int PLAN_LEN = 26;
  localparam plan_step_t PLAN [PLAN_LEN] = '{
    '{OP_FILL, 1'b0, 7'd0, 6'd0, 6'd0, CELL_A, 17'd65536, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd65536, 5'd24},
    '{OP_FILL, 1'b0, 7'd0, 6'd0, 6'd0, CELL_B, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd0, 5'd24},
    '{OP_FILL, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd131071, 17'd131071, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd0, 5'd0},
    '{OP_FILL, 1'b0, 7'd0, 6'd0, 6'd0, CELL_OTHER, 17'd131071, 17'd131071, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd0, 5'd0},
    '{OP_FILL, 1'b0, 7'd0, 6'd0, 6'd0, CELL_B, 17'd0, 17'd131071, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd131071, 5'd24},
    '{OP_WRITE, 1'b0, 7'd0, 6'd1, 6'd1, CELL_A, 17'd0, 17'd5, 1'b0, 17'd0, 5'd0},
    '{OP_WRITE, 1'b0, 7'd0, 6'd63, 6'd62, CELL_A, 17'd12345, 17'd77, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_WRITE, 1'b0, 7'd0, 6'd0, 6'd0, CELL_A, 17'd131071, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_CFG, CFG_ROWS, 7'd0, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_CFG, CFG_COLS, 7'd127, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_FILL, 1'b0, 7'd0, 6'd2, 6'd2, CELL_A, 17'd1, 17'd131071, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd63, 6'd2, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd1, 5'd24},
    '{OP_CFG, CFG_ROWS, 7'd127, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_CFG, CFG_COLS, 7'd3, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_FILL, 1'b0, 7'd0, 6'd40, 6'd2, CELL_B, 17'd0, 17'd65535, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd40, 6'd63, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd65535, 5'd24},
    '{OP_CFG, CFG_ROWS, 7'd5, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_CFG, CFG_COLS, 7'd5, 6'd0, 6'd0, CELL_EMPTY, 17'd0, 17'd0, 1'b0, 17'd0, 5'd0},
    '{OP_QUERY, 1'b0, 7'd0, 6'd63, 6'd63, CELL_EMPTY, 17'd0, 17'd0, 1'b1, 17'd1, 5'd24}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  tnm_pkg::tnm_in_t    in_data;
  logic                out_valid;
  logic                out_stall;
  tnm_pkg::tnm_out_t   out_data;
  logic                cfg_we;
  logic                cfg_idx;
  logic [DIM_BITS-1:0] cfg_data;

  logic [1:0]            cell_state_q [GRID_CELLS];
  logic [TRAIT_BITS-1:0] cell_a_q [GRID_CELLS];
  logic [TRAIT_BITS-1:0] cell_b_q [GRID_CELLS];
  bit                    cell_written_q [GRID_CELLS];
  int                    rows_in_use;
  int                    cols_in_use;

  tnm_pkg::tnm_out_t pending_means [$];
  tnm_pkg::tnm_out_t mean_head;
  int                mismatch_count = 0;
  int                items_sent = 0;
  int                gap_pct = 10;
  bit                quiet = 1'b0;
  int                stall_left = 0;
  int                calm_left = 0;

  torus_neighborhood_trait_mean_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp_dim(logic [DIM_BITS-1:0] value);
    if (value < tnm_pkg::MIN_DIM) return int'(tnm_pkg::MIN_DIM);
    if (int'(value) > GRID_STRIDE) return GRID_STRIDE;
    return int'(value);
  endfunction

  function automatic int wrap(int base, int off, int n);
    return (base + n + off - 2) % n;
  endfunction

  function automatic tnm_pkg::tnm_out_t neighborhood_mean(logic [ROW_BITS-1:0] row,
                                                          logic [ROW_BITS-1:0] col);
    tnm_pkg::tnm_out_t res;
    int                cr;
    int                cc;
    int                addr;
    int                dr;
    int                dc;
    int unsigned       sum;
    int unsigned       alive;
    int unsigned       quo;
    cr    = int'(row) % rows_in_use;
    cc    = int'(col) % cols_in_use;
    sum   = 0;
    alive = 0;
    for (dr = 0; dr < 5; dr++) begin
      for (dc = 0; dc < 5; dc++) begin
        if (dr == 2 && dc == 2) continue;
        addr = wrap(cr, dr, rows_in_use) * GRID_STRIDE + wrap(cc, dc, cols_in_use);
        if (cell_state_q[addr] == CELL_A) begin
          sum += cell_a_q[addr];
          alive++;
        end else if (cell_state_q[addr] == CELL_B) begin
          sum += cell_b_q[addr];
          alive++;
        end
      end
    end
    quo             = (alive != 0) ? (sum / alive) : 0;
    res.alive_count = alive[COUNT_BITS-1:0];
    res.mean_trait  = quo[MEAN_BITS-1:0];
    return res;
  endfunction

  function automatic tnm_pkg::tnm_in_t cell_item(logic req, int row, int col, logic [1:0] st,
                                                 logic [TRAIT_BITS-1:0] a,
                                                 logic [TRAIT_BITS-1:0] b);
    tnm_pkg::tnm_in_t item;
    item.req_type   = req;
    item.cell_row   = ROW_BITS'(row);
    item.cell_col   = ROW_BITS'(col);
    item.cell_state = st;
    item.trait_a    = a;
    item.trait_b    = b;
    return item;
  endfunction

  function automatic logic [TRAIT_BITS-1:0] rand_trait();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return TRAIT_BITS'(65536);
      2: return '1;
      3, 4: return TRAIT_BITS'($urandom_range(0, 65536));
      default: return TRAIT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rand_state();
    if ($urandom_range(0, 3) == 0) return 2'($urandom_range(0, 3));
    return ($urandom_range(0, 1) != 0) ? CELL_A : CELL_B;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 1) != 0) return $urandom_range(0, 63);
    return $urandom_range(0, 9);
  endfunction

  function automatic tnm_pkg::tnm_in_t random_write(int row, int col);
    return cell_item(tnm_pkg::REQ_WRITE, row, col, rand_state(), rand_trait(), rand_trait());
  endfunction

  task automatic go_idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic send_item(tnm_pkg::tnm_in_t item, logic typed,
                           tnm_pkg::tnm_out_t typed_mean);
    int addr;
    if (!quiet && $urandom_range(0, 99) < gap_pct) go_idle($urandom_range(1, 18));
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (item.req_type == tnm_pkg::REQ_WRITE) begin
      addr = int'(item.cell_row) * GRID_STRIDE + int'(item.cell_col);
      cell_state_q[addr]   = item.cell_state;
      cell_a_q[addr]       = item.trait_a;
      cell_b_q[addr]       = item.trait_b;
      cell_written_q[addr] = 1'b1;
    end else begin
      pending_means.push_back(typed ? typed_mean
                                    : neighborhood_mean(item.cell_row, item.cell_col));
    end
  endtask

  task automatic wait_for_results();
    go_idle(1);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (QUERY_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid_reg(logic idx, logic [DIM_BITS-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ROWS) rows_in_use = clamp_dim(value);
    else cols_in_use = clamp_dim(value);
  endtask

  // Writes every unwritten neighbor of a random center, sometimes rewrites a few, then queries.
  task automatic query_sequence();
    int qr;
    int qc;
    int cr;
    int cc;
    int r;
    int c;
    int dr;
    int dc;
    qr = rand_coord();
    qc = rand_coord();
    cr = qr % rows_in_use;
    cc = qc % cols_in_use;
    for (dr = 0; dr < 5; dr++) begin
      for (dc = 0; dc < 5; dc++) begin
        r = wrap(cr, dr, rows_in_use);
        c = wrap(cc, dc, cols_in_use);
        if ((dr != 2 || dc != 2) && !cell_written_q[r * GRID_STRIDE + c])
          send_item(random_write(r, c), 1'b0, '0);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        r = wrap(cr, $urandom_range(0, 4), rows_in_use);
        c = wrap(cc, $urandom_range(0, 4), cols_in_use);
        send_item(random_write(r, c), 1'b0, '0);
      end
    end
    send_item(cell_item(tnm_pkg::REQ_QUERY, qr, qc, 2'($urandom), rand_trait(), rand_trait()),
              1'b0, '0);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (calm_left > 0) begin
        out_stall = 1'b0;
        calm_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 200);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_means.size() == 0) begin
        if (mismatch_count < 10)
          $display("Unexpected result transaction: mean %0d count %0d",
                   out_data.mean_trait, out_data.alive_count);
        mismatch_count++;
      end else begin
        mean_head = pending_means.pop_front();
        if (out_data.mean_trait !== mean_head.mean_trait ||
            out_data.alive_count !== mean_head.alive_count) begin
          if (mismatch_count < 10)
            $display("Mismatch: expected mean %0d count %0d, got mean %0d count %0d",
                     mean_head.mean_trait, mean_head.alive_count,
                     out_data.mean_trait, out_data.alive_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int                  i;
    int                  dr;
    int                  dc;
    int                  phase;
    int                  phase_end;
    int                  random_base;
    logic [DIM_BITS-1:0] raw_rows;
    logic [DIM_BITS-1:0] raw_cols;
    tnm_pkg::tnm_out_t   typed_mean;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_ROWS;
    cfg_data    = '0;
    rows_in_use = GRID_STRIDE;
    cols_in_use = GRID_STRIDE;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < PLAN_LEN; i++) begin
      typed_mean.mean_trait  = PLAN[i].mean;
      typed_mean.alive_count = PLAN[i].count;
      case (PLAN[i].op)
        OP_CFG: begin
          write_grid_reg(PLAN[i].cfg_idx, PLAN[i].cfg_val);
        end
        OP_WRITE: begin
          send_item(cell_item(tnm_pkg::REQ_WRITE, PLAN[i].row, PLAN[i].col, PLAN[i].st,
                              PLAN[i].a, PLAN[i].b), 1'b0, '0);
        end
        OP_QUERY: begin
          send_item(cell_item(tnm_pkg::REQ_QUERY, PLAN[i].row, PLAN[i].col, PLAN[i].st,
                              PLAN[i].a, PLAN[i].b), PLAN[i].typed, typed_mean);
        end
        default: begin
          for (dr = 0; dr < 5; dr++) begin
            for (dc = 0; dc < 5; dc++) begin
              send_item(cell_item(tnm_pkg::REQ_WRITE, wrap(PLAN[i].row, dr, rows_in_use),
                                  wrap(PLAN[i].col, dc, cols_in_use), PLAN[i].st,
                                  PLAN[i].a, PLAN[i].b), 1'b0, '0);
            end
          end
        end
      endcase
    end

    phase       = 0;
    random_base = items_sent;
    while (items_sent - random_base < ITEMS) begin
      case (phase % 6)
        0: begin
          raw_rows = DIM_BITS'($urandom_range(5, 12));
          raw_cols = DIM_BITS'($urandom_range(5, 12));
        end
        1: begin
          raw_rows = tnm_pkg::MIN_DIM;
          raw_cols = tnm_pkg::MIN_DIM;
        end
        2: begin
          raw_rows = ($urandom_range(0, 1) != 0) ? DIM_BITS'(64)
                                                 : DIM_BITS'($urandom_range(65, 127));
          raw_cols = DIM_BITS'($urandom_range(5, 8));
        end
        3: begin
          raw_rows = DIM_BITS'($urandom_range(0, 4));
          raw_cols = DIM_BITS'($urandom_range(5, 10));
        end
        4: begin
          raw_rows = DIM_BITS'($urandom_range(5, 10));
          raw_cols = DIM_BITS'($urandom_range(64, 127));
        end
        default: begin
          raw_rows = ($urandom_range(0, 1) != 0) ? DIM_BITS'(64)
                                                 : DIM_BITS'($urandom_range(13, 40));
          raw_cols = ($urandom_range(0, 1) != 0) ? DIM_BITS'(64)
                                                 : DIM_BITS'($urandom_range(13, 40));
        end
      endcase
      write_grid_reg(CFG_ROWS, raw_rows);
      write_grid_reg(CFG_COLS, raw_cols);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 5;
        default: gap_pct = 20;
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent - random_base < ITEMS) begin
        if (items_sent - random_base >= ITEMS - QUIET_ITEMS) quiet = 1'b1;
        if ($urandom_range(0, 9) < 7) query_sequence();
        else send_item(random_write($urandom_range(0, 63), $urandom_range(0, 63)), 1'b0, '0);
      end
      phase++;
    end

    wait_for_results();
    if (mismatch_count == 0 && pending_means.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
